// File: sv/scope_edge_trigger_finder_top_defines.svh
// assertion macros for the trigger finder top module
`ifndef SCOPE_EDGE_TRIGGER_FINDER_TOP_DEFINES_SVH
`define SCOPE_EDGE_TRIGGER_FINDER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SETF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("setf assertion failed");

// next-cycle implication, checked outside reset
`define SETF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("setf assertion failed");

`endif

// File: sv/setf_pkg.sv
`default_nettype none

package setf_pkg;

  // fixed field widths
  localparam int SampleBits = 12;
  localparam int IndexW     = 10;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 12;

  // history and smoothing
  localparam int HistLen     = 5;
  localparam int SmoothStart = 5;
  localparam int SumW        = SampleBits + 4;

  // defaults
  localparam int BufferDepthDefault = 1024;
  localparam logic [SampleBits-1:0] NearZeroReset = SampleBits'(100);

  typedef logic [SampleBits-1:0] sample_t;
  typedef logic [HistLen-1:0][SampleBits-1:0] hist_t;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgSlopeNegative   = 2'd0,
    CfgTriggerThresh   = 2'd1,
    CfgNearZeroLimit   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic    slope_negative;
    sample_t trigger_threshold;
    sample_t near_zero_limit;
  } cfg_t;

  // decision for one sample
  typedef struct packed {
    logic              emit;
    logic              found;
    logic [IndexW-1:0] index;
    logic              last;
    logic              set_reported;
  } det_t;

endpackage

`default_nettype wire

// File: sv/scope_edge_trigger_finder_top.sv
`default_nettype none

// Edge trigger finder for one capture buffer of ADC samples. Samples enter one
// per cycle; each word is held in an input register, checked against the five
// samples before it by combinational compare and 1-2-3-2-1 sum logic, and a
// result (found with its index, or not found at buffer end) lands in an output
// register. A new sample is taken every cycle while the result side keeps up;
// the input register and the output register each hold one word, so a waiting
// result does not stall the input until both are full. At most one result per
// buffer. There is no clearing pass after reset. Write configuration only while
// no sample is in flight.

module scope_edge_trigger_finder_top
  import setf_pkg::*;
#(
  parameter int BUFFER_DEPTH = BufferDepthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // sample channel
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [SampleBits-1:0] sample_i,
  input  wire logic                end_of_buffer_i,
  // result channel
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     found_o,
  output logic [IndexW-1:0]        trigger_index_o,
  // configuration channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  `include "scope_edge_trigger_finder_top_defines.svh"

  localparam int PosW = $clog2(BUFFER_DEPTH);

  cfg_t            cfg;
  hist_t           hist;
  logic [PosW-1:0] pos;
  logic            reported;
  det_t            det;

  logic            s1_valid_q, s1_valid_d;
  sample_t         s1_sample_q;
  logic            s1_eob_q;
  logic            out_valid_q, out_valid_d;
  logic            found_q;
  logic [IndexW-1:0] index_q;

  logic out_free, step, in_acc;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  setf_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // stage control
  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = det.emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q <= SampleBits'(sample_i);
      s1_eob_q    <= end_of_buffer_i;
    end
  end

  // buffer state and trigger decision
  setf_history #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_history (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .sample_i   (s1_sample_q),
    .det_i      (det),
    .hist_o     (hist),
    .pos_o      (pos),
    .reported_o (reported)
  );

  setf_detect #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_detect (
    .cfg_i      (cfg),
    .hist_i     (hist),
    .pos_i      (pos),
    .reported_i (reported),
    .sample_i   (s1_sample_q),
    .eob_i      (s1_eob_q),
    .det_o      (det)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && det.emit) begin
      found_q <= det.found;
      index_q <= det.index;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign trigger_index_o = index_q;

  // checks
  `SETF_ASSERT_NOW(a_notfound_index_zero, clk_i, rst_ni,
    out_valid_o && !found_o, trigger_index_o == '0)
  `SETF_ASSERT_NOW(a_stall_only_when_full, clk_i, rst_ni,
    !in_ready_o, s1_valid_q && out_valid_q)
  `SETF_ASSERT_NEXT(a_stage_word_kept, clk_i, rst_ni,
    s1_valid_q && !out_free, s1_valid_q)
  `SETF_ASSERT_NEXT(a_hit_reaches_output, clk_i, rst_ni,
    step && det.found, out_valid_q && found_q)

endmodule

`default_nettype wire

// File: sv/setf_cfg_regs.sv
`default_nettype none

module setf_cfg_regs
  import setf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_en_i,
  input  wire logic [CfgIdxW-1:0]  wr_index_i,
  input  wire logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  // register write decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_reg_e'(wr_index_i))
        CfgSlopeNegative: cfg_d.slope_negative    = wr_data_i[0];
        CfgTriggerThresh: cfg_d.trigger_threshold = SampleBits'(wr_data_i);
        CfgNearZeroLimit: cfg_d.near_zero_limit   = SampleBits'(wr_data_i);
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slope_negative    <= 1'b0;
      cfg_q.trigger_threshold <= '0;
      cfg_q.near_zero_limit   <= NearZeroReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: sv/setf_history.sv
`default_nettype none

module setf_history
  import setf_pkg::*;
#(
  parameter int BUFFER_DEPTH = BufferDepthDefault,
  localparam int PosW = $clog2(BUFFER_DEPTH)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire sample_t         sample_i,
  input  wire det_t            det_i,
  output hist_t                hist_o,
  output logic [PosW-1:0]      pos_o,
  output logic                 reported_o
);

  hist_t           hist_q, hist_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            reported_q, reported_d;

  // buffer state: clear at buffer end, otherwise shift in the sample
  always_comb begin
    hist_d     = hist_q;
    pos_d      = pos_q;
    reported_d = reported_q;
    if (step_i) begin
      if (det_i.last) begin
        hist_d     = '0;
        pos_d      = '0;
        reported_d = 1'b0;
      end else begin
        hist_d     = {hist_q[HistLen-2:0], sample_i};
        pos_d      = pos_q + PosW'(1);
        reported_d = reported_q | det_i.set_reported;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q     <= '0;
      pos_q      <= '0;
      reported_q <= 1'b0;
    end else begin
      hist_q     <= hist_d;
      pos_q      <= pos_d;
      reported_q <= reported_d;
    end
  end

  assign hist_o     = hist_q;
  assign pos_o      = pos_q;
  assign reported_o = reported_q;

endmodule

`default_nettype wire

// File: sv/setf_detect.sv
`default_nettype none

module setf_detect
  import setf_pkg::*;
#(
  parameter int BUFFER_DEPTH = BufferDepthDefault,
  localparam int PosW = $clog2(BUFFER_DEPTH)
) (
  input  wire cfg_t            cfg_i,
  input  wire hist_t           hist_i,
  input  wire logic [PosW-1:0] pos_i,
  input  wire logic            reported_i,
  input  wire sample_t         sample_i,
  input  wire logic            eob_i,
  output det_t                 det_o
);

  logic [SumW-1:0] sum_cur, sum_prev;
  sample_t         h0;
  logic            hit;
  logic [PosW-1:0] hit_pos;
  logic            last;

  assign h0 = hist_i[0];

  // 1-2-3-2-1 smoothed sums at this index and the one before
  assign sum_cur = SumW'(hist_i[3]) + (SumW'(hist_i[2]) << 1)
                 + (SumW'(hist_i[1]) << 1) + SumW'(hist_i[1])
                 + (SumW'(hist_i[0]) << 1) + SumW'(sample_i);
  assign sum_prev = SumW'(hist_i[4]) + (SumW'(hist_i[3]) << 1)
                  + (SumW'(hist_i[2]) << 1) + SumW'(hist_i[2])
                  + (SumW'(hist_i[1]) << 1) + SumW'(hist_i[0]);

  // final sample of the buffer, forced at the last slot
  assign last = eob_i || (pos_i == PosW'(BUFFER_DEPTH - 1));

  // edge conditions
  always_comb begin
    hit     = 1'b0;
    hit_pos = pos_i;
    if (cfg_i.trigger_threshold == '0) begin
      if (pos_i != '0) begin
        if (!cfg_i.slope_negative) begin
          hit     = (h0 <= cfg_i.near_zero_limit) && (sample_i > h0);
          hit_pos = pos_i - PosW'(1);
        end else begin
          hit     = (sample_i <= cfg_i.near_zero_limit) && (h0 > sample_i);
        end
      end
    end else if (pos_i >= PosW'(SmoothStart)) begin
      if (!cfg_i.slope_negative) begin
        hit = (sample_i >= cfg_i.trigger_threshold)
           && (h0 < cfg_i.trigger_threshold) && (sum_prev < sum_cur);
      end else begin
        hit = (sample_i <= cfg_i.trigger_threshold)
           && (h0 > cfg_i.trigger_threshold) && (sum_prev > sum_cur);
      end
    end
  end

  // result word and state update flags
  always_comb begin
    det_o.emit         = !reported_i && (hit || last);
    det_o.found        = !reported_i && hit;
    det_o.index        = (!reported_i && hit) ? IndexW'(hit_pos) : '0;
    det_o.last         = last;
    det_o.set_reported = !reported_i && hit;
  end

endmodule

`default_nettype wire
